@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies a property in the same cycle.
`define ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Condition in this cycle implies a property in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/biu_pkg.sv @@
package biu_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE     = 2'd2;

   // request kinds
   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_COMPUTE = 1'b1;

   // sequencing
   localparam int CNT_W       = 5;
   localparam int QUO_W       = 15;  // quotient bits of a Q2.14 weight magnitude
   localparam int COORD_W     = 11;
   localparam int COORD_STEPS = 11;
   localparam int WGT_READS   = 8;
   localparam int TAP_COUNT   = 16;

   // arithmetic
   localparam int WT_W     = 16;
   localparam int TAP_W    = 14;
   localparam int ACC_W    = 45;
   localparam int ACC_FRAC = 28;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BLD_MUL1,
      ST_BLD_MUL2,
      ST_BLD_NUM,
      ST_BLD_PREP,
      ST_BLD_DIV,
      ST_BLD_WR,
      ST_COORD,
      ST_CHECK,
      ST_WGT,
      ST_TAP,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       bld_start;
      logic       bld_mul1;
      logic       bld_mul2;
      logic       bld_num;
      logic       bld_prep;
      logic       bld_div;
      logic       bld_wr;
      logic       coord_step;
      logic       check;
      logic       wgt_issue;
      logic       tap_issue;
      logic       out_load;
      logic [3:0] idx;
   } cmd_type;

   typedef struct packed {
      logic bld_last;
      logic oor;
      logic rsp_busy;
   } sts_type;

endpackage

@@ hw/rtl/biu_ctrl.sv @@
module biu_ctrl
   import biu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_func,
   output logic                 req_stall,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  sts_type              sts,
   output cmd_type              cmd
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rebuild_ff, rebuild_in;
   logic             rebuild_clr;

   // state, step counter and table rebuild flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         rebuild_ff <= 1'b1;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rebuild_ff <= rebuild_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      cmd         = '0;
      cmd.idx     = cnt_ff[3:0];
      rebuild_clr = 1'b0;
      req_stall   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = rebuild_ff;
            if (rebuild_ff) begin
               cmd.bld_start = 1'b1;
               rebuild_clr   = 1'b1;
               state_in      = ST_BLD_MUL1;
            end else if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_func == FUNC_COMPUTE) begin
                  cnt_in   = '0;
                  state_in = ST_COORD;
               end
            end
         end
         ST_BLD_MUL1: begin
            cmd.bld_mul1 = 1'b1;
            state_in     = ST_BLD_MUL2;
         end
         ST_BLD_MUL2: begin
            cmd.bld_mul2 = 1'b1;
            state_in     = ST_BLD_NUM;
         end
         ST_BLD_NUM: begin
            cmd.bld_num = 1'b1;
            state_in    = ST_BLD_PREP;
         end
         ST_BLD_PREP: begin
            cmd.bld_prep = 1'b1;
            cnt_in       = '0;
            state_in     = ST_BLD_DIV;
         end
         ST_BLD_DIV: begin
            cmd.bld_div = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = ST_BLD_WR;
            end
         end
         ST_BLD_WR: begin
            cmd.bld_wr = 1'b1;
            state_in   = sts.bld_last ? ST_IDLE : ST_BLD_MUL1;
         end
         ST_COORD: begin
            cmd.coord_step = 1'b1;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(COORD_STEPS - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            cnt_in    = '0;
            state_in  = sts.oor ? ST_FIN : ST_WGT;
         end
         ST_WGT: begin
            cmd.wgt_issue = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WGT_READS - 1)) begin
               cnt_in   = '0;
               state_in = ST_TAP;
            end
         end
         ST_TAP: begin
            cmd.tap_issue = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TAP_COUNT - 1)) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: begin
            state_in = ST_DRAIN2;
         end
         ST_DRAIN2: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!sts.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rebuild_in = (rebuild_ff & ~rebuild_clr) | (csr_we & (csr_index == REG_SCALE));
   end

endmodule

@@ hw/rtl/biu_datapath.sv @@
module biu_datapath
   import biu_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_SCALE  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_func,
   input  logic [7:0]            req_src_col,
   input  logic [7:0]            req_src_row,
   input  logic [7:0]            req_src_red,
   input  logic [7:0]            req_src_green,
   input  logic [7:0]            req_src_blue,
   input  logic [COORD_W-1:0]    req_dst_col,
   input  logic [COORD_W-1:0]    req_dst_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_red,
   output logic [7:0]            rsp_out_green,
   output logic [7:0]            rsp_out_blue,
   output logic                  rsp_status,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output sts_type               sts
);

   localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WEW    = $clog2(MAX_WIDTH + 1);
   localparam int HEW    = $clog2(MAX_HEIGHT + 1);
   localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int FAW    = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
   localparam int SW     = $clog2(MAX_SCALE + 1);
   localparam int DW     = SW + 1;
   localparam int UW     = DW + 1;
   localparam int TDEPTH = 4 * MAX_SCALE + 1;
   localparam int TAW    = $clog2(TDEPTH);
   localparam int NW     = 3 * UW + 5;
   localparam int RW     = 3 * DW + 2;
   localparam int DVW    = NW + 14;
   localparam int PRW    = 9 + 2 * WT_W;

   // configuration registers
   logic [CSR_DATA_W-1:0] in_width_ff, in_height_ff;
   logic [3:0]            scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff  <= CSR_DATA_W'(1);
         in_height_ff <= CSR_DATA_W'(1);
         scale_ff     <= 4'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_IN_WIDTH:  in_width_ff  <= csr_wdata;
            REG_IN_HEIGHT: in_height_ff <= csr_wdata;
            REG_SCALE:     scale_ff     <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // registers limited to their legal range
   logic [WEW-1:0] w_eff;
   logic [HEW-1:0] h_eff;
   logic [SW-1:0]  s_eff;
   logic [DW-1:0]  d_eff;

   always_comb begin
      if (in_width_ff == '0)                 w_eff = WEW'(1);
      else if (32'(in_width_ff) > MAX_WIDTH) w_eff = WEW'(MAX_WIDTH);
      else                                   w_eff = WEW'(in_width_ff);
      if (in_height_ff == '0)                  h_eff = HEW'(1);
      else if (32'(in_height_ff) > MAX_HEIGHT) h_eff = HEW'(MAX_HEIGHT);
      else                                     h_eff = HEW'(in_height_ff);
      if (scale_ff == '0)                  s_eff = SW'(1);
      else if (32'(scale_ff) > MAX_SCALE)  s_eff = SW'(MAX_SCALE);
      else                                 s_eff = SW'(scale_ff);
      d_eff = {s_eff, 1'b0};
   end

   // ---------------- kernel table build ----------------
   logic [UW-1:0]          u_ff;
   logic [2*UW-1:0]        u2_ff;
   logic [2*DW-1:0]        dd_ff;
   logic [3*UW-1:0]        u3_ff;
   logic [2*UW+DW-1:0]     u2d_ff;
   logic [UW+2*DW-1:0]     ud2_ff;
   logic [3*DW-1:0]        d3_ff;
   logic signed [NW-1:0]   num_ff, num_in;
   logic                   neg_ff;
   logic [RW-1:0]          rem_ff, rem_t, den_x;
   logic [QUO_W-1:0]       lo_ff;
   logic [NW-1:0]          mag;
   logic [DVW-1:0]         dvd;
   logic signed [WT_W-1:0] wval;

   // kernel numerator for distance u/D
   always_comb begin
      logic signed [NW-1:0] a3, a2d, ad2, ad3;
      a3  = signed'(NW'(u3_ff));
      a2d = signed'(NW'(u2d_ff));
      ad2 = signed'(NW'(ud2_ff));
      ad3 = signed'(NW'(d3_ff));
      if (u_ff <= UW'(d_eff)) begin
         num_in = (a3 <<< 1) + a3 - ((a2d <<< 2) + a2d) + (ad3 <<< 1);
      end else if (u_ff < {d_eff, 1'b0}) begin
         num_in = (a2d <<< 2) + a2d - a3 - (ad2 <<< 3) + (ad3 <<< 2);
      end else begin
         num_in = '0;
      end
      mag   = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
      dvd   = {mag, 14'd0} + DVW'(d3_ff);
      den_x = RW'({d3_ff, 1'b0});
      rem_t = {rem_ff[RW-2:0], lo_ff[QUO_W-1]};
      wval  = neg_ff ? -signed'(WT_W'(lo_ff)) : signed'(WT_W'(lo_ff));
   end

   always_ff @(posedge clock) begin
      if (cmd.bld_start) u_ff <= '0;
      else if (cmd.bld_wr) u_ff <= u_ff + 1'b1;
      if (cmd.bld_mul1) begin
         u2_ff <= (2*UW)'(u_ff) * (2*UW)'(u_ff);
         dd_ff <= (2*DW)'(d_eff) * (2*DW)'(d_eff);
      end
      if (cmd.bld_mul2) begin
         u3_ff  <= (3*UW)'(u2_ff) * (3*UW)'(u_ff);
         u2d_ff <= (2*UW+DW)'(u2_ff) * (2*UW+DW)'(d_eff);
         ud2_ff <= (UW+2*DW)'(u_ff) * (UW+2*DW)'(dd_ff);
         d3_ff  <= (3*DW)'(dd_ff) * (3*DW)'(d_eff);
      end
      if (cmd.bld_num) num_ff <= num_in;
      // rounded magnitude division, one quotient bit a cycle
      if (cmd.bld_prep) begin
         neg_ff <= num_ff[NW-1];
         rem_ff <= RW'(dvd >> QUO_W);
         lo_ff  <= dvd[QUO_W-1:0];
      end else if (cmd.bld_div) begin
         if (rem_t >= den_x) begin
            rem_ff <= rem_t - den_x;
            lo_ff  <= {lo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_t;
            lo_ff  <= {lo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   // ---------------- coordinate division by scale ----------------
   logic [COORD_W-1:0]       xq_ff, yq_ff;
   logic [SW-1:0]            xr_ff, yr_ff;
   logic [SW:0]              xrt, yrt, x2r1, y2r1;
   logic                     xge, yge;
   logic signed [COORD_W:0]  i0x_ff, i0y_ff;
   logic [DW-1:0]            nx_ff, ny_ff;
   logic [UW-1:0]            nx_t, ny_t;
   logic                     oor_ff;

   always_comb begin
      xrt  = {xr_ff, xq_ff[COORD_W-1]};
      yrt  = {yr_ff, yq_ff[COORD_W-1]};
      x2r1 = {xr_ff, 1'b1};
      y2r1 = {yr_ff, 1'b1};
      xge  = x2r1 >= {1'b0, s_eff};
      yge  = y2r1 >= {1'b0, s_eff};
      nx_t = xge ? UW'(x2r1) - UW'(s_eff) : UW'(x2r1) + UW'(s_eff);
      ny_t = yge ? UW'(y2r1) - UW'(s_eff) : UW'(y2r1) + UW'(s_eff);
   end

   // quotient at or beyond the image size means the output is out of range
   assign sts.oor = (32'(xq_ff) >= 32'(w_eff)) || (32'(yq_ff) >= 32'(h_eff));

   always_ff @(posedge clock) begin
      if (cmd.accept && (req_func == FUNC_COMPUTE)) begin
         xq_ff <= req_dst_col;
         yq_ff <= req_dst_row;
         xr_ff <= '0;
         yr_ff <= '0;
      end else if (cmd.coord_step) begin
         if (xrt >= {1'b0, s_eff}) begin
            xr_ff <= SW'(xrt - {1'b0, s_eff});
            xq_ff <= {xq_ff[COORD_W-2:0], 1'b1};
         end else begin
            xr_ff <= SW'(xrt);
            xq_ff <= {xq_ff[COORD_W-2:0], 1'b0};
         end
         if (yrt >= {1'b0, s_eff}) begin
            yr_ff <= SW'(yrt - {1'b0, s_eff});
            yq_ff <= {yq_ff[COORD_W-2:0], 1'b1};
         end else begin
            yr_ff <= SW'(yrt);
            yq_ff <= {yq_ff[COORD_W-2:0], 1'b0};
         end
      end
      // first tap position and fraction
      if (cmd.check) begin
         i0x_ff <= xge ? $signed({1'b0, xq_ff})
                       : $signed({1'b0, xq_ff}) - $signed((COORD_W+1)'(1));
         i0y_ff <= yge ? $signed({1'b0, yq_ff})
                       : $signed({1'b0, yq_ff}) - $signed((COORD_W+1)'(1));
         nx_ff  <= DW'(nx_t);
         ny_ff  <= DW'(ny_t);
         oor_ff <= sts.oor;
      end
   end

   // ---------------- kernel table ----------------
   logic signed [WT_W-1:0] wtab [TDEPTH];
   logic signed [WT_W-1:0] tq_ff;
   logic signed [WT_W-1:0] xw_ff [4];
   logic signed [WT_W-1:0] yw_ff [4];
   logic [2:0]             wsel_ff;
   logic                   wv_ff;
   logic [UW-1:0]          wdist;

   // distances of the four taps: n+D, n, D-n, 2D-n
   always_comb begin
      logic [UW-1:0] nn, dd;
      nn = cmd.idx[2] ? UW'(ny_ff) : UW'(nx_ff);
      dd = UW'(d_eff);
      case (cmd.idx[1:0])
         2'd0:    wdist = nn + dd;
         2'd1:    wdist = nn;
         2'd2:    wdist = dd - nn;
         default: wdist = (dd << 1) - nn;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.bld_wr) wtab[TAW'(u_ff)] <= wval;
      else if (cmd.wgt_issue) tq_ff <= wtab[TAW'(wdist)];
   end

   always_ff @(posedge clock) begin
      if (reset) wv_ff <= 1'b0;
      else       wv_ff <= cmd.wgt_issue;
      wsel_ff <= cmd.idx[2:0];
      if (wv_ff) begin
         if (wsel_ff[2]) yw_ff[wsel_ff[1:0]] <= tq_ff;
         else            xw_ff[wsel_ff[1:0]] <= tq_ff;
      end
   end

   // ---------------- frame store and accumulation ----------------
   function automatic logic [TAP_W-1:0] clamp_tap(logic signed [COORD_W:0] i0,
                                                  logic [1:0] k,
                                                  logic [TAP_W-1:0] size);
      logic signed [TAP_W-1:0] t;
      t = TAP_W'(i0) + TAP_W'($signed({1'b0, k})) - $signed(TAP_W'(1));
      if (t < 0)                       clamp_tap = '0;
      else if (t >= $signed(size))     clamp_tap = size - 1'b1;
      else                             clamp_tap = TAP_W'(t);
   endfunction

   function automatic logic [7:0] round_sat(logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0]      t;
      logic [ACC_W-ACC_FRAC-1:0]    v;
      t = a + $signed(ACC_W'(1) << (ACC_FRAC - 1));
      v = t[ACC_W-1:ACC_FRAC];
      if (a < 0)                              round_sat = 8'd0;
      else if (v > (ACC_W-ACC_FRAC)'(255))    round_sat = 8'hFF;
      else                                    round_sat = 8'(v);
   endfunction

   logic [23:0]               fstore [FDEPTH];
   logic [23:0]               fq_ff;
   logic [TAP_W-1:0]          xi, yi;
   logic [FAW-1:0]            tap_addr, ld_addr;
   logic                      ld_we;
   logic signed [2*WT_W-1:0]  wt_ff;
   logic signed [PRW-1:0]     pr_r_ff, pr_g_ff, pr_b_ff;
   logic                      v1_ff, v2_ff;
   logic signed [ACC_W-1:0]   acc_r_ff, acc_g_ff, acc_b_ff;

   always_comb begin
      xi       = clamp_tap(i0x_ff, cmd.idx[1:0], TAP_W'(w_eff));
      yi       = clamp_tap(i0y_ff, cmd.idx[3:2], TAP_W'(h_eff));
      tap_addr = FAW'(32'(yi[YW-1:0]) * MAX_WIDTH + 32'(xi[XW-1:0]));
      ld_addr  = FAW'(32'(req_src_row) * MAX_WIDTH + 32'(req_src_col));
      ld_we    = cmd.accept && (req_func == FUNC_LOAD) &&
                 (32'(req_src_col) < MAX_WIDTH) && (32'(req_src_row) < MAX_HEIGHT);
   end

   // single port: loads write, taps read
   always_ff @(posedge clock) begin
      if (ld_we) fstore[ld_addr] <= {req_src_red, req_src_green, req_src_blue};
      else if (cmd.tap_issue) fq_ff <= fstore[tap_addr];
   end

   // tap pipeline: read and weight product, sample products, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.tap_issue;
         v2_ff <= v1_ff;
      end
      wt_ff   <= yw_ff[cmd.idx[3:2]] * xw_ff[cmd.idx[1:0]];
      pr_r_ff <= $signed({1'b0, fq_ff[23:16]}) * wt_ff;
      pr_g_ff <= $signed({1'b0, fq_ff[15:8]}) * wt_ff;
      pr_b_ff <= $signed({1'b0, fq_ff[7:0]}) * wt_ff;
      if (cmd.check) begin
         acc_r_ff <= '0;
         acc_g_ff <= '0;
         acc_b_ff <= '0;
      end else if (v2_ff) begin
         acc_r_ff <= acc_r_ff + ACC_W'(pr_r_ff);
         acc_g_ff <= acc_g_ff + ACC_W'(pr_g_ff);
         acc_b_ff <= acc_b_ff + ACC_W'(pr_b_ff);
      end
   end

   // ---------------- output register ----------------
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cmd.out_load | (rsp_valid_ff & rsp_stall);
      if (cmd.out_load) begin
         rsp_out_red   <= oor_ff ? 8'd0 : round_sat(acc_r_ff);
         rsp_out_green <= oor_ff ? 8'd0 : round_sat(acc_g_ff);
         rsp_out_blue  <= oor_ff ? 8'd0 : round_sat(acc_b_ff);
         rsp_status    <= oor_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign sts.rsp_busy = rsp_valid_ff & rsp_stall;
   assign sts.bld_last = (u_ff == {d_eff, 1'b0});

endmodule

@@ hw/rtl/bicubic_integer_upscaler.sv @@
// Bicubic upscaler, Keys kernel, integer scale factor.
// Request channel (req_*): func 0 loads one RGB source pixel into the frame
// store and is done in the cycle it is taken; func 1 asks for one output
// pixel and yields one response on rsp_* with alpha fixed at 255.
// A compute request, once accepted, runs the coordinate division by the
// scale, a range check, 8 kernel table reads and 16 frame store reads (one
// tap per cycle on its single port), then drains the multiply-accumulate
// pipe and loads the output register. Out of range coordinates skip the
// table and frame store reads and return status 1. One compute request is
// in flight at a time; the next can be taken from the cycle after the load.
// After reset and after every write to the scale register the kernel table
// is rebuilt over 4*scale+1 entries; req_stall is high meanwhile.
// Register writes belong between requests.
// The response sits in an output register: a new request may be taken while
// it is stalled, but the next result waits until rsp_stall drops.
// The frame store holds no reset value; reads of unloaded pixels are garbage.
module bicubic_integer_upscaler
   import biu_pkg::*;
#(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_SCALE  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [7:0]            req_src_col,
   input  logic [7:0]            req_src_row,
   input  logic [7:0]            req_src_red,
   input  logic [7:0]            req_src_green,
   input  logic [7:0]            req_src_blue,
   input  logic [COORD_W-1:0]    req_dst_col,
   input  logic [COORD_W-1:0]    req_dst_row,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_red,
   output logic [7:0]            rsp_out_green,
   output logic [7:0]            rsp_out_blue,
   output logic [7:0]            rsp_out_alpha,
   output logic                  rsp_status,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   biu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .sts       (sts),
      .cmd       (cmd)
   );

   biu_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_SCALE  (MAX_SCALE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_func      (req_func),
      .req_src_col   (req_src_col),
      .req_src_row   (req_src_row),
      .req_src_red   (req_src_red),
      .req_src_green (req_src_green),
      .req_src_blue  (req_src_blue),
      .req_dst_col   (req_dst_col),
      .req_dst_row   (req_dst_row),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_status    (rsp_status),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .sts           (sts)
   );

   // alpha is opaque on every response
   assign rsp_out_alpha = 8'hFF;

endmodule

@@ hw/rtl/biu_checker.sv @@
`include "assert_macros.svh"

module biu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_red,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_blue,
   input logic [7:0] rsp_out_alpha,
   input logic       rsp_status
);

   // colour and status of the response as one word
   logic [24:0] rsp_payload;

   assign rsp_payload = {rsp_out_red, rsp_out_green, rsp_out_blue, rsp_status};

   // a stalled response stays and holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))

   // alpha always opaque; an error response carries black
   `ASSERT_NOW(a_alpha, clock, reset, rsp_valid, rsp_out_alpha == 8'hFF)
   `ASSERT_NOW(a_err_black, clock, reset, rsp_valid && rsp_status, rsp_payload[24:1] == 24'd0)

endmodule

bind bicubic_integer_upscaler biu_checker u_biu_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_out_alpha (rsp_out_alpha),
   .rsp_status    (rsp_status)
);
